// ===== rtl/ufe_pkg.sv =====
// Shared types, codes and character helpers for the form-style percent encoder.
package ufe_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LIMIT_W = 12;
  localparam int unsigned COUNT_W = 13;
  localparam int unsigned KIND_W  = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd500;

  // Command kinds handed from the front to the back
  localparam logic [KIND_W-1:0] KIND_CHAR = 2'd0;  // one literal character
  localparam logic [KIND_W-1:0] KIND_HEX  = 2'd1;  // '%' plus two hex digits
  localparam logic [KIND_W-1:0] KIND_TERM = 2'd2;  // end of message

  localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_NUL     = 8'h00;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  data;     // mapped char, or raw byte for hex
    logic [COUNT_W-1:0] length;   // terminator only
    logic               trunc;    // terminator only
  } ufe_entry_t;

  // Unreserved characters pass through unchanged
  function automatic logic is_pass(input logic [BYTE_W-1:0] c);
    logic r;
    r = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
        ((c >= 8'h30) && (c <= 8'h39)) ||
        (c == 8'h2D) || (c == 8'h5F) || (c == 8'h2E) || (c == 8'h7E);
    return r;
  endfunction

  // Upper-case hex digit for one nibble
  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n);
    logic [BYTE_W-1:0] r;
    if (n < 4'd10) begin
      r = 8'h30 + {4'd0, n};
    end else begin
      r = 8'h37 + {4'd0, n};
    end
    return r;
  endfunction

endpackage

// ===== rtl/ufe_front.sv =====
// Front end: accepts source bytes, classifies them, tracks length and stop state.
module ufe_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ufe_pkg::BYTE_W-1:0]  source_byte,
  input  logic [ufe_pkg::LIMIT_W-1:0] length_limit,
  input  logic                        q_full,
  output logic                        push,
  output ufe_pkg::ufe_entry_t         push_entry
);
  import ufe_pkg::*;

  logic [COUNT_W-1:0] output_count;
  logic [COUNT_W-1:0] output_count_next;
  logic               stopped_flag;
  logic               accept;
  logic               is_end;
  logic               esc;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign is_end   = (source_byte == CH_NUL);
  assign esc      = !is_pass(source_byte) && (source_byte != CH_SPACE);
  assign push     = accept && (is_end || !stopped_flag);

  assign output_count_next = output_count + (esc ? COUNT_W'(3) : COUNT_W'(1));

  // Classify the byte into a back-end command
  always_comb begin
    push_entry.length = '0;
    push_entry.trunc  = 1'b0;
    push_entry.data   = source_byte;
    if (is_end) begin
      push_entry.kind   = KIND_TERM;
      push_entry.data   = CH_NUL;
      push_entry.length = output_count;
      push_entry.trunc  = stopped_flag;
    end else if (esc) begin
      push_entry.kind = KIND_HEX;
    end else begin
      push_entry.kind = KIND_CHAR;
      if (source_byte == CH_SPACE) begin
        push_entry.data = CH_PLUS;
      end
    end
  end

  // Running length and stop flag
  always_ff @(posedge clk) begin
    if (rst) begin
      output_count <= '0;
      stopped_flag <= 1'b0;
    end else if (push) begin
      if (is_end) begin
        output_count <= '0;
        stopped_flag <= 1'b0;
      end else begin
        output_count <= output_count_next;
        if (output_count_next >= {1'b0, length_limit}) begin
          stopped_flag <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/ufe_queue.sv =====
// Short command queue between the front and the back.
module ufe_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ufe_pkg::ufe_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output ufe_pkg::ufe_entry_t head
);
  import ufe_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ufe_entry_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full  = (fill == CNT_W'(DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/ufe_back.sv =====
// Back end: expands queued commands into output characters, one beat per unstalled cycle.
module ufe_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        empty,
  input  ufe_pkg::ufe_entry_t         head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ufe_pkg::BYTE_W-1:0]  out_char,
  output logic                        last_of_run,
  output logic                        end_of_message,
  output logic [ufe_pkg::COUNT_W-1:0] encoded_length,
  output logic                        truncated
);
  import ufe_pkg::*;

  logic [1:0]        step;
  logic              load;
  logic              take;
  logic [BYTE_W-1:0] ch;
  logic              last;

  assign load = !out_valid || !out_stall;
  assign take = load && !empty;
  assign pop  = take && last;

  // Pick the character for the current step of the head command
  always_comb begin
    ch   = head.data;
    last = 1'b1;
    unique case (head.kind)
      KIND_HEX: begin
        case (step)
          2'd0:    begin ch = CH_PERCENT;               last = 1'b0; end
          2'd1:    begin ch = hex_char(head.data[7:4]); last = 1'b0; end
          default: begin ch = hex_char(head.data[3:0]); last = 1'b1; end
        endcase
      end
      KIND_TERM: ch = CH_NUL;
      default:   ch = head.data;
    endcase
  end

  // Step counter within an escaped byte
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (take) begin
      step <= last ? 2'd0 : step + 2'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_char       <= ch;
      last_of_run    <= last;
      end_of_message <= (head.kind == KIND_TERM);
      encoded_length <= (head.kind == KIND_TERM) ? head.length : '0;
      truncated      <= (head.kind == KIND_TERM) && head.trunc;
    end
  end

endmodule

// ===== rtl/url_form_percent_encoder.sv =====
// Form-style percent encoder top level: config register, front, queue, back.
// Throughput: one output character per cycle while out_stall is low; a pass-through or
//   space byte yields one character, an escaped byte three, a zero byte one, and a byte
//   dropped after the stop none. The single-character output register sets this figure.
// Path: a byte is queued first; its first character then loads the output register.
// Reset (rst, synchronous): clears length, stop flag, queue and output valid;
//   length_limit returns to 500.
module url_form_percent_encoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ufe_pkg::LIMIT_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ufe_pkg::BYTE_W-1:0]  source_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ufe_pkg::BYTE_W-1:0]  out_char,
  output logic                        last_of_run,
  output logic                        end_of_message,
  output logic [ufe_pkg::COUNT_W-1:0] encoded_length,
  output logic                        truncated
);
  import ufe_pkg::*;

  logic [LIMIT_W-1:0] length_limit;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  ufe_entry_t         q_in;
  ufe_entry_t         q_head;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      length_limit <= cfg_data;
    end
  end

  ufe_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .source_byte  (source_byte),
    .length_limit (length_limit),
    .q_full       (q_full),
    .push         (q_push),
    .push_entry   (q_in)
  );

  ufe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  ufe_back u_back (
    .clk            (clk),
    .rst            (rst),
    .empty          (q_empty),
    .head           (q_head),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .last_of_run    (last_of_run),
    .end_of_message (end_of_message),
    .encoded_length (encoded_length),
    .truncated      (truncated)
  );

  // Checks
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(q_push && q_full))
    else $error("queue written while full");
  a_term_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_message) |-> (last_of_run && (out_char == CH_NUL)))
    else $error("terminator beat malformed");
  a_char_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !end_of_message) |-> ((encoded_length == '0) && !truncated))
    else $error("length or flag set on character beat");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(q_pop && q_empty))
    else $error("queue read while empty");

endmodule
